// ===== rtl/sitoa_pkg.sv =====
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and controller/datapath interface types for the signed
// integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned DigitCount  = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned BitsPerStep = 4;   // double-dabble bits consumed per cycle
  localparam int unsigned ConvSteps   = ValueWidth / BitsPerStep;
  localparam int unsigned StepCntW    = $clog2(ConvSteps);
  localparam int unsigned CharW       = 6;
  localparam int unsigned LenW        = 4;

  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  typedef logic [DigitCount-1:0][3:0] bcd_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture a new value, clear the BCD accumulator
    logic step;  // one double-dabble step
    logic emit;  // move the next character into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can take a character this cycle
    logic last;      // the character at the current position is the final one
  } status_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit two's-complement value to its decimal ASCII text,
// one character per transfer, sign first, final character marked.
// ----------------------------------------------------------------------------
// Sequence: the input transfer loads the value, the double-dabble conversion
//   runs 4 bits per cycle, then characters move one per cycle through the
//   output register while it is not stalled; a text has 1..11 characters, and
//   a new value is taken only after its final character has been emitted.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module signed_int_to_decimal_ascii (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [sitoa_pkg::ValueWidth-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sitoa_pkg::CharW-1:0]        character_o,
  output logic                               is_last_o,
  output logic [sitoa_pkg::LenW-1:0]         text_length_o
);

  sitoa_pkg::cmd_t    cmd;
  sitoa_pkg::status_t status;

  sitoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sitoa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .character_o   (character_o),
    .is_last_o     (is_last_o),
    .text_length_o (text_length_o)
  );

  // a new value is never taken while a conversion is in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // input stays blocked until the final character has been produced
  a_no_accept_mid_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> in_stall_o)
    else $error("input open in the middle of a text");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == sitoa_pkg::CharMinus) ||
                    ((character_o >= sitoa_pkg::CharZero) &&
                     (character_o <= sitoa_pkg::CharZero + 6'd9)))
    else $error("character out of range");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (text_length_o >= 4'd1) && (text_length_o <= 4'd11))
    else $error("text length out of range");

endmodule

// ===== rtl/sitoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Sequencer: accepts a value, runs the double-dabble steps, then emits
// characters until the final one has been transferred into the output stage.
// ----------------------------------------------------------------------------
module sitoa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sitoa_pkg::status_t  status_i,
  output sitoa_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [sitoa_pkg::StepCntW-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == sitoa_pkg::StepCntW'(sitoa_pkg::ConvSteps - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/sitoa_dpath.sv =====
// ----------------------------------------------------------------------------
// sitoa_dpath
// Magnitude and BCD registers with a 4-bit-per-cycle double-dabble step,
// digit count, character select and the output register.
// ----------------------------------------------------------------------------
module sitoa_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [sitoa_pkg::ValueWidth-1:0]     value_i,
  input  sitoa_pkg::cmd_t                      cmd_i,
  output sitoa_pkg::status_t                   status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sitoa_pkg::CharW-1:0]          character_o,
  output logic                                 is_last_o,
  output logic [sitoa_pkg::LenW-1:0]           text_length_o
);

  logic                              neg_q;
  logic [sitoa_pkg::ValueWidth-1:0]  mag_q, mag_d;
  sitoa_pkg::bcd_t                   bcd_q, bcd_d;
  logic [sitoa_pkg::LenW-1:0]        pos_q;
  logic                              out_valid_q;
  logic [sitoa_pkg::CharW-1:0]       char_q;
  logic                              last_q;
  logic [sitoa_pkg::LenW-1:0]        len_q;

  logic [sitoa_pkg::LenW-1:0]        num_digits;
  logic [sitoa_pkg::LenW-1:0]        total_len;
  logic [sitoa_pkg::LenW-1:0]        digit_idx;
  logic [sitoa_pkg::CharW-1:0]       cur_char;
  logic                              cur_last;

  // one conversion step: BitsPerStep rounds of add-3 then shift
  always_comb begin
    sitoa_pkg::bcd_t                  bcd_v;
    logic [sitoa_pkg::ValueWidth-1:0] mag_v;
    bcd_v = bcd_q;
    mag_v = mag_q;
    for (int s = 0; s < sitoa_pkg::BitsPerStep; s++) begin
      for (int d = 0; d < sitoa_pkg::DigitCount; d++) begin
        if (bcd_v[d] >= 4'd5) begin
          bcd_v[d] = bcd_v[d] + 4'd3;
        end
      end
      {bcd_v, mag_v} = {bcd_v, mag_v} << 1;
    end
    bcd_d = bcd_v;
    mag_d = mag_v;
  end

  // digit count up to the highest nonzero digit; zero still gives one digit
  always_comb begin
    num_digits = 4'd1;
    for (int d = 1; d < sitoa_pkg::DigitCount; d++) begin
      if (bcd_q[d] != 4'd0) begin
        num_digits = sitoa_pkg::LenW'(d + 1);
      end
    end
  end

  assign total_len = num_digits + {{(sitoa_pkg::LenW-1){1'b0}}, neg_q};
  assign digit_idx = total_len - 4'd1 - pos_q;
  assign cur_last  = (pos_q == total_len - 4'd1);

  always_comb begin
    if (neg_q && (pos_q == '0)) begin
      cur_char = sitoa_pkg::CharMinus;
    end else begin
      cur_char = sitoa_pkg::CharZero + {2'b00, bcd_q[digit_idx]};
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.last     = cur_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_i[sitoa_pkg::ValueWidth-1];
      mag_q <= value_i[sitoa_pkg::ValueWidth-1] ? (~value_i + 1'b1) : value_i;
      bcd_q <= '0;
    end else if (cmd_i.step) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end
    if (cmd_i.emit) begin
      char_q <= cur_char;
      last_q <= cur_last;
      len_q  <= total_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        pos_q <= '0;
      end else if (cmd_i.emit) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign character_o   = char_q;
  assign is_last_o     = last_q;
  assign text_length_o = len_q;

endmodule

// ===== tb/signed_int_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Self-checking bench for the decimal text converter. A directed table covers
// zero, single digits, digit-count boundaries and both extremes; random values
// then sweep every digit count and sign. Each character transfer is checked
// against an in-bench prediction, with random gaps on the input side and
// random stalls plus one long hold-off on the output side.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int unsigned Radix       = 10;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned QuietLimit  = 5000;  // cycles without any transfer
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned HoldAfter   = 1500;  // characters seen before the hold-off

  typedef struct packed {
    logic [sitoa_pkg::CharW-1:0] ch;
    logic                        last;
    logic [sitoa_pkg::LenW-1:0]  len;
  } text_char_t;

  logic                                      clk_i;
  logic                                      rst_ni;
  logic                                      in_valid_i;
  logic                                      in_stall_o;
  logic signed [sitoa_pkg::ValueWidth-1:0]   value_i;
  logic                                      out_valid_o;
  logic                                      out_stall_i = 1'b0;
  logic [sitoa_pkg::CharW-1:0]               character_o;
  logic                                      is_last_o;
  logic [sitoa_pkg::LenW-1:0]                text_length_o;

  text_char_t                       pending_chars[$];
  logic [sitoa_pkg::ValueWidth-1:0] table_value[$];
  string                            table_text[$];
  int unsigned                      errors = 0;
  int unsigned                      chars_seen = 0;
  bit                               hold_done = 0;
  int unsigned                      stall_left = 0;
  int unsigned                      rx_cycle = 0;

  signed_int_to_decimal_ascii i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .character_o   (character_o),
    .is_last_o     (is_last_o),
    .text_length_o (text_length_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Expected characters of the decimal text of one word.
  task automatic predict_text(input logic [sitoa_pkg::ValueWidth-1:0] word);
    logic                             neg;
    logic [sitoa_pkg::ValueWidth-1:0] mag;
    logic [3:0]                       digs [sitoa_pkg::DigitCount];
    int                               nd;
    int                               total;
    text_char_t                       c;
    neg = word[sitoa_pkg::ValueWidth-1];
    mag = neg ? (~word + 1'b1) : word;
    nd  = 0;
    do begin
      digs[nd] = 4'(mag % Radix);
      nd++;
      mag = mag / Radix;
    end while (mag != 0 && nd < sitoa_pkg::DigitCount);
    total = nd + (neg ? 1 : 0);
    if (neg) begin
      c.ch   = sitoa_pkg::CharMinus;
      c.last = 1'b0;
      c.len  = sitoa_pkg::LenW'(total);
      pending_chars.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch   = sitoa_pkg::CharZero + sitoa_pkg::CharW'(digs[k]);
      c.last = (k == 0);
      c.len  = sitoa_pkg::LenW'(total);
      pending_chars.push_back(c);
    end
  endtask

  task automatic expect_text(input string s);
    byte        b;
    text_char_t c;
    for (int i = 0; i < s.len(); i++) begin
      b      = s[i];
      c.ch   = b[sitoa_pkg::CharW-1:0];
      c.last = (i == s.len() - 1);
      c.len  = sitoa_pkg::LenW'(s.len());
      pending_chars.push_back(c);
    end
  endtask

  // Offer one value after a gap; expectations are queued at the transfer.
  task automatic send_value(input logic [sitoa_pkg::ValueWidth-1:0] v, input string text,
                            input int unsigned gap);
    bit done;
    for (int unsigned g = 0; g < gap; g++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    done = 0;
    while (!done) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        done = 1;
        if (text.len() != 0) expect_text(text);
        else predict_text(v);
      end
    end
  endtask

  function automatic logic [sitoa_pkg::ValueWidth-1:0] random_value();
    int unsigned r;
    int unsigned nd;
    longint      lo;
    longint      hi;
    longint      mag;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) begin
      nd = $urandom_range(1, sitoa_pkg::DigitCount);
      lo = 1;
      for (int unsigned i = 1; i < nd; i++) lo = lo * Radix;
      hi = lo * Radix - 1;
      if (nd == 1) lo = 0;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      mag = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
      if ($urandom_range(0, 1) == 1) mag = -mag;
      return sitoa_pkg::ValueWidth'(mag);
    end
    if (r == 8) begin
      mag = 1;
      nd  = $urandom_range(0, sitoa_pkg::DigitCount - 1);
      for (int unsigned i = 0; i < nd; i++) mag = mag * Radix;
      mag = mag + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1) == 1) mag = -mag;
      return sitoa_pkg::ValueWidth'(mag);
    end
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      default: return 32'h8000_0001;
    endcase
  endfunction

  task automatic add_row(input logic [sitoa_pkg::ValueWidth-1:0] v, input string text);
    table_value.push_back(v);
    table_text.push_back(text);
  endtask

  // Output side: random stalls, calm stretches, and one long hold-off.
  always @(negedge clk_i) begin
    rx_cycle++;
    if (!hold_done && chars_seen >= HoldAfter) begin
      hold_done  = 1;
      stall_left = HoldCycles;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ((rx_cycle / 128) % 4 == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left   = idle_len();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    text_char_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected char transfer: char %0d last %0b len %0d", $time,
                 character_o, is_last_o, text_length_o);
      end else begin
        e = pending_chars.pop_front();
        if (character_o !== e.ch) begin
          errors++;
          $display("%0t: character: expected %0d, got %0d", $time, e.ch, character_o);
        end
        if (is_last_o !== e.last) begin
          errors++;
          $display("%0t: is_last: expected %0b, got %0b", $time, e.last, is_last_o);
        end
        if (text_length_o !== e.len) begin
          errors++;
          $display("%0t: text_length: expected %0d, got %0d", $time, e.len,
                   text_length_o);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;

    // Empty text means: predict it.
    add_row('0,           "0");
    add_row(32'd1,        "1");
    add_row('1,           "-1");
    add_row(32'd7,        "7");
    add_row(32'd9,        "9");
    add_row(-32'sd9,      "");
    add_row(32'd10,       "");
    add_row(-32'sd10,     "");
    add_row(32'd99,       "");
    add_row(32'd100,      "");
    add_row(32'd999999999, "");
    add_row(32'd1000000000, "1000000000");
    add_row(-32'sd1000000000, "");
    add_row(32'd1999999999, "");
    add_row(32'd123456789, "");
    add_row(-32'sd987654321, "");
    add_row(32'h7fff_ffff, "2147483647");
    add_row(32'h7fff_fffe, "");
    add_row(32'h8000_0000, "-2147483648");
    add_row(32'h8000_0001, "");
    add_row(32'h5555_5555, "");
    add_row(32'haaaa_aaaa, "");

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (table_value[i]) send_value(table_value[i], table_text[i], idle_len());

    for (int unsigned n = 0; n < RandomItems; n++) begin
      send_value(random_value(), "", (n % 64 < 12) ? 0 : idle_len());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sitoa_pkg.sv
rtl/sitoa_ctrl.sv
rtl/sitoa_dpath.sv
rtl/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_test.sv
